### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### hw/rtl/msmu_pkg.sv
// Shared types, widths and the exponential table of the spin update block.
// No dependencies.
`timescale 1ns / 1ps
package msmu_pkg;
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int EXP_IDX_W   = $clog2(EXP_TABLE_ENTRIES);
    localparam int NUM_COEFFS  = 6;
    localparam int COEFF_W     = 32;
    localparam int MOM_W       = 16;
    localparam int DRAW_W      = 16;
    localparam int MAG_W       = 17;
    localparam int ACC_W       = 48;
    localparam int ACC_HALF    = 24;
    localparam int FRAC_W      = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int STEP_W      = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BETA = 3'd6;
    localparam logic OP_SET = 1'b1;

    typedef logic [15:0] t_exp_tab [EXP_TABLE_ENTRIES];

    typedef struct packed {
        logic                    op;
        logic signed [MOM_W-1:0] trial;
        logic [MAG_W-1:0]        mag;
        logic [DRAW_W-1:0]       draw;
    } t_item;

    typedef struct packed {
        logic [NUM_COEFFS-1:0][COEFF_W-1:0] coeff;
        logic [31:0]                        beta;
    } t_cfg;

    function automatic t_exp_tab exp_table_fill();
        t_exp_tab          tab;
        logic [63:0]       y;
        logic [63:0]       term;
        logic [63:0]       f;
        logic [63:0]       v;
        logic [63:0]       e;
        logic signed [63:0] sum;
        y    = (64'd16 << 30) / EXP_TABLE_ENTRIES;
        term = 64'd1 << 30;
        sum  = 64'sd1 <<< 30;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * y) >> 30) / 64'(k);
            if (k % 2 == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        f = (sum > 0) ? $unsigned(sum) : 64'd0;
        v = 64'd1 << 30;
        for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
            if (k > 0) v = (v * f + (64'd1 << 29)) >> 30;
            e = (v + (64'd1 << 13)) >> 14;
            tab[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TABLE = exp_table_fill();
endpackage

### hw/rtl/msmu_front.sv
// Front end: takes items, derives the absolute moment, holds them in a
// short queue for the back end. Depends on msmu_pkg.
`timescale 1ns / 1ps
module msmu_front import msmu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_operation,
    input  logic signed [MOM_W-1:0] i_trial_moment,
    input  logic [DRAW_W-1:0]       i_uniform_draw,
    output logic                    o_item_valid,
    output t_item                   o_item,
    input  logic                    i_pop
);
    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    t_item               w_item;
    logic                w_push;
    logic signed [MAG_W-1:0] w_ext;

    assign o_in_ready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push       = i_in_valid && o_in_ready;
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_ext        = MAG_W'(i_trial_moment);

    always_comb begin
        w_item.op    = i_operation;
        w_item.trial = i_trial_moment;
        w_item.mag   = w_ext[MAG_W-1] ? $unsigned(-w_ext) : $unsigned(w_ext);
        w_item.draw  = i_uniform_draw;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= w_item;
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= QPTR_W'((32'(r_wr_ptr) + 1) % QUEUE_DEPTH);
            if (i_pop)  r_rd_ptr <= QPTR_W'((32'(r_rd_ptr) + 1) % QUEUE_DEPTH);
            r_count <= r_count + QCNT_W'(w_push) - QCNT_W'(i_pop);
        end
    end
endmodule

### hw/rtl/msmu_poly.sv
// Iterative Horner evaluation of the energy polynomial, each step a P_MUL state
// (split partial products), then a P_ADD state (shift and add). Depends on msmu_pkg.
`timescale 1ns / 1ps
module msmu_poly import msmu_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [MAG_W-1:0]          i_mag,
    input  t_cfg                      i_cfg,
    output logic                      o_done,
    output logic signed [COEFF_W-1:0] o_energy
);
    typedef enum logic [1:0] {P_IDLE, P_MUL, P_ADD} t_pstate;

    t_pstate                      r_state;
    logic [STEP_W-1:0]            r_step;
    logic [MAG_W-1:0]             r_mag;
    logic signed [ACC_W-1:0]      r_acc;
    logic [ACC_HALF+MAG_W-1:0]    r_pp_lo;
    logic signed [ACC_HALF+MAG_W:0] r_pp_hi;
    logic signed [ACC_W+MAG_W+1:0] w_sum;
    logic signed [ACC_W-1:0]      w_acc;
    logic signed [COEFF_W-1:0]    w_c;

    localparam logic signed [ACC_W-1:0] E_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] E_MIN = -ACC_W'(64'sd2147483648);

    always_comb begin
        w_c   = $signed(i_cfg.coeff[r_step]);
        w_sum = ($signed((ACC_W+MAG_W+2)'(r_pp_hi)) <<< ACC_HALF)
              + $signed({{3{1'b0}}, r_pp_lo});
        // floor shift, then next coefficient
        w_acc = $signed(w_sum[ACC_W+FRAC_W-1:FRAC_W]) + ACC_W'(w_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_mag   <= i_mag;
                        r_acc   <= ACC_W'($signed(i_cfg.coeff[0]));
                        r_step  <= STEP_W'(1);
                        r_state <= P_MUL;
                    end
                end
                P_MUL: begin
                    r_pp_lo <= r_acc[ACC_HALF-1:0] * r_mag;
                    r_pp_hi <= $signed(r_acc[ACC_W-1:ACC_HALF]) * $signed({1'b0, r_mag});
                    r_state <= P_ADD;
                end
                P_ADD: begin
                    r_acc <= w_acc;
                    if (r_step == STEP_W'(NUM_COEFFS - 1)) begin
                        o_done <= 1'b1;
                        if (w_acc > E_MAX) o_energy <= E_MAX[COEFF_W-1:0];
                        else if (w_acc < E_MIN) o_energy <= E_MIN[COEFF_W-1:0];
                        else o_energy <= w_acc[COEFF_W-1:0];
                        r_state <= P_IDLE;
                    end else begin
                        r_step  <= r_step + STEP_W'(1);
                        r_state <= P_MUL;
                    end
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/msmu_back.sv
// Back end: energy, difference, Boltzmann test against the table, held
// spin state and the result register. Depends on msmu_pkg, msmu_poly, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msmu_back import msmu_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_item_valid,
    input  t_item                     i_item,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_accepted,
    output logic signed [MOM_W-1:0]   o_moment,
    output logic signed [COEFF_W-1:0] o_energy,
    output logic signed [COEFF_W-1:0] o_energy_change
);
    typedef enum logic [2:0] {B_IDLE, B_WAIT, B_DIFF, B_MUL, B_DEC} t_bstate;

    t_bstate                     r_state;
    t_item                       r_item;
    logic signed [MOM_W-1:0]     r_cur_moment;
    logic signed [COEFF_W-1:0]   r_cur_energy;
    logic signed [COEFF_W-1:0]   r_e_new;
    logic signed [COEFF_W:0]     r_de;
    logic [63:0]                 r_x;
    logic                        w_done;
    logic signed [COEFF_W-1:0]   w_energy;
    logic                        w_take;
    logic [15:0]                 w_exp;
    logic signed [COEFF_W-1:0]   w_de_sat;

    assign o_pop = (r_state == B_IDLE) && i_item_valid && !o_out_valid;

    msmu_poly u_poly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (o_pop),
        .i_mag    (i_item.mag),
        .i_cfg    (i_cfg),
        .o_done   (w_done),
        .o_energy (w_energy)
    );

    always_comb begin
        w_exp = EXP_TABLE[r_x[39:40-EXP_IDX_W]];
        w_take = (r_item.op == OP_SET) || r_de[COEFF_W] || (r_de == '0)
               || ((r_x[63:40] == '0) && (r_item.draw < w_exp));
        if (r_de[COEFF_W] != r_de[COEFF_W-1])
            w_de_sat = r_de[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}}
                                     : {1'b0, {(COEFF_W-1){1'b1}}};
        else
            w_de_sat = r_de[COEFF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            o_out_valid  <= 1'b0;
            r_cur_moment <= '0;
            r_cur_energy <= '0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_item  <= i_item;
                        r_state <= B_WAIT;
                    end
                end
                B_WAIT: begin
                    if (w_done) begin
                        r_e_new <= w_energy;
                        r_state <= B_DIFF;
                    end
                end
                B_DIFF: begin
                    r_de    <= {r_e_new[COEFF_W-1], r_e_new}
                             - {r_cur_energy[COEFF_W-1], r_cur_energy};
                    r_state <= B_MUL;
                end
                B_MUL: begin
                    // only a positive difference reaches the table, so 32 bits do
                    r_x     <= r_de[COEFF_W-1:0] * i_cfg.beta;
                    r_state <= B_DEC;
                end
                B_DEC: begin
                    o_out_valid     <= 1'b1;
                    o_accepted      <= w_take;
                    o_energy_change <= w_de_sat;
                    if (w_take) begin
                        r_cur_moment <= r_item.trial;
                        r_cur_energy <= r_e_new;
                        o_moment     <= r_item.trial;
                        o_energy     <= r_e_new;
                    end else begin
                        o_moment <= r_cur_moment;
                        o_energy <= r_cur_energy;
                    end
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_done_in_wait, i_clk, i_rst_n, w_done |-> (r_state == B_WAIT))
    `ASSERT_CLK(a_reject_holds, i_clk, i_rst_n,
        (r_state == B_DEC && !w_take) |=> $stable(r_cur_moment) && $stable(r_cur_energy))
    `ASSERT_NEVER(a_pop_while_full, i_clk, i_rst_n, o_pop && o_out_valid)
endmodule

### hw/rtl/metropolis_spin_moment_update.sv
// Single-spin Metropolis update. From input accept to result valid: the item is
// popped to start, the five Horner steps run on the shared multiply unit, the
// energy is taken, then come the difference, beta product and decision.
// One item at a time in the back end, and the next starts only once the result
// is taken.
// Synchronous active-low reset clears the configuration, the control state and the held moment and energy to zero.
`timescale 1ns / 1ps
module metropolis_spin_moment_update import msmu_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_operation,
    input  logic signed [MOM_W-1:0]   i_trial_moment,
    input  logic [DRAW_W-1:0]         i_uniform_draw,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_accepted,
    output logic signed [MOM_W-1:0]   o_moment,
    output logic signed [COEFF_W-1:0] o_energy,
    output logic signed [COEFF_W-1:0] o_energy_change,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]               i_cfg_data
);
    t_cfg  r_cfg;
    logic  w_item_valid;
    t_item w_item;
    logic  w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index < CFG_IDX_W'(NUM_COEFFS))
                r_cfg.coeff[i_cfg_index] <= i_cfg_data;
            else if (i_cfg_index == REG_BETA)
                r_cfg.beta <= i_cfg_data;
        end
    end

    msmu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_trial_moment (i_trial_moment),
        .i_uniform_draw (i_uniform_draw),
        .o_item_valid   (w_item_valid),
        .o_item         (w_item),
        .i_pop          (w_pop)
    );

    msmu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item_valid    (w_item_valid),
        .i_item          (w_item),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_moment        (o_moment),
        .o_energy        (o_energy),
        .o_energy_change (o_energy_change)
    );
endmodule
